@@ rtl/osa_pkg.sv @@
// ----------------------------------------------------------------------------
// OSA edit distance package
// Shared sizes, function codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int MAX_LEN   = 32;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CH_W      = 8;
  localparam int FUNC_W    = 2;
  localparam int DIST_W    = 6;
  localparam int DIST_MAX  = (1 << DIST_W) - 1;
  localparam int SUM_W     = LEN_W + 1;
  localparam int SAT_W     = (LEN_W > DIST_W) ? LEN_W : DIST_W;
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int NUM_ROWS  = 3;
  localparam int ROW_SEL_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_APPEND_A = 2'd1,
    FUNC_APPEND_B = 2'd2,
    FUNC_COMPUTE  = 2'd3
  } func_t;

  typedef struct packed {
    logic load;
    logic start;
    logic row_init;
    logic sweep;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic n_zero;
    logic j_last;
    logic i_last;
  } ctrl_status_t;

endpackage

@@ rtl/osa_req_if.sv @@
// ----------------------------------------------------------------------------
// OSA request channel
// Valid/ready channel carrying one function code and one byte per word.
// ----------------------------------------------------------------------------
interface osa_req_if;
  logic                        valid;
  logic                        ready;
  logic [osa_pkg::FUNC_W-1:0]  func;
  logic [osa_pkg::CH_W-1:0]    ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

@@ rtl/osa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// OSA response channel
// Valid/ready channel carrying one distance and the truncation flag per word.
// ----------------------------------------------------------------------------
interface osa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [osa_pkg::DIST_W-1:0]  distance;
  logic                        truncated;

  modport source (output valid, output distance, output truncated, input ready);
  modport sink   (input valid, input distance, input truncated, output ready);
endinterface

@@ rtl/osa_ctrl.sv @@
// ----------------------------------------------------------------------------
// OSA controller
// Sequences loads, the row-by-row cell sweep and the result handoff.
// ----------------------------------------------------------------------------
module osa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [osa_pkg::FUNC_W-1:0] req_func,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  osa_pkg::ctrl_status_t      status,
  output osa_pkg::ctrl_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROW  = 4'b0010,
    S_CELL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (osa_pkg::func_t'(req_func) == osa_pkg::FUNC_COMPUTE) begin
            cmd.start  = 1'b1;
            state_next = (status.m_zero || status.n_zero) ? S_DONE : S_ROW;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_ROW: begin
        cmd.row_init = 1'b1;
        state_next   = S_CELL;
      end
      S_CELL: begin
        cmd.sweep = 1'b1;
        if (status.j_last) begin
          state_next = status.i_last ? S_DONE : S_ROW;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/osa_datapath.sv @@
// ----------------------------------------------------------------------------
// OSA datapath
// Word stores, three rotating row memories and the recurrence, one cell per
// cycle within a row, with its sliding window of neighbor values.
// ----------------------------------------------------------------------------
module osa_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  osa_pkg::ctrl_cmd_t         cmd,
  input  logic [osa_pkg::FUNC_W-1:0] func,
  input  logic [osa_pkg::CH_W-1:0]   ch,
  output osa_pkg::ctrl_status_t      status,
  output logic [osa_pkg::DIST_W-1:0] distance,
  output logic                       truncated
);

  logic [osa_pkg::CH_W-1:0]  word_a [osa_pkg::MAX_LEN];
  logic [osa_pkg::CH_W-1:0]  word_b [osa_pkg::MAX_LEN];
  logic [osa_pkg::LEN_W-1:0] row_mem [osa_pkg::NUM_ROWS][osa_pkg::ROW_DEPTH];
  logic [osa_pkg::LEN_W-1:0] row_rd [osa_pkg::NUM_ROWS];

  logic [osa_pkg::LEN_W-1:0]     len_a;
  logic [osa_pkg::LEN_W-1:0]     len_b;
  logic                          overflow_seen;
  logic [osa_pkg::LEN_W-1:0]     i_cnt;
  logic [osa_pkg::LEN_W-1:0]     j_cnt;
  logic [osa_pkg::ROW_SEL_W-1:0] rot;
  logic [osa_pkg::CH_W-1:0]      a_rd;
  logic [osa_pkg::CH_W-1:0]      a_prev;
  logic [osa_pkg::CH_W-1:0]      b_rd;
  logic [osa_pkg::CH_W-1:0]      b_prev;
  logic [osa_pkg::LEN_W-1:0]     p1_left;
  logic [osa_pkg::LEN_W-1:0]     p2_d1;
  logic [osa_pkg::LEN_W-1:0]     p2_d2;
  logic [osa_pkg::LEN_W-1:0]     cur_left;

  logic [osa_pkg::ROW_SEL_W-1:0] rot_next;
  logic [osa_pkg::ROW_SEL_W-1:0] p1_sel;
  logic [osa_pkg::ROW_SEL_W-1:0] p2_sel;
  logic [osa_pkg::LEN_W-1:0]     p1_val;
  logic [osa_pkg::LEN_W-1:0]     p2_val;
  logic [osa_pkg::LEN_W-1:0]     rd_addr;
  logic [osa_pkg::LEN_W-1:0]     a_addr;
  logic [osa_pkg::SUM_W-1:0]     del_c;
  logic [osa_pkg::SUM_W-1:0]     ins_c;
  logic [osa_pkg::SUM_W-1:0]     sub_c;
  logic [osa_pkg::SUM_W-1:0]     tr_c;
  logic [osa_pkg::SUM_W-1:0]     min1;
  logic [osa_pkg::SUM_W-1:0]     min2;
  logic [osa_pkg::SUM_W-1:0]     min3;
  logic                          trans_ok;
  logic [osa_pkg::LEN_W-1:0]     cell_val;
  logic [osa_pkg::LEN_W-1:0]     result;
  logic [osa_pkg::SAT_W-1:0]     result_wide;
  logic                          a_room;
  logic                          b_room;

  assign status.m_zero = (len_a == '0);
  assign status.n_zero = (len_b == '0);
  assign status.j_last = (j_cnt == len_b);
  assign status.i_last = (i_cnt == len_a);

  assign a_room = (len_a < osa_pkg::LEN_W'(osa_pkg::MAX_LEN));
  assign b_room = (len_b < osa_pkg::LEN_W'(osa_pkg::MAX_LEN));

  // current row is rot, previous row rot+1, the one before rot+2 (mod 3)
  always_comb begin
    unique case (rot)
      2'd0:    begin p1_sel = 2'd1; p2_sel = 2'd2; rot_next = 2'd2; end
      2'd1:    begin p1_sel = 2'd2; p2_sel = 2'd0; rot_next = 2'd0; end
      2'd2:    begin p1_sel = 2'd0; p2_sel = 2'd1; rot_next = 2'd1; end
      default: begin p1_sel = 2'd1; p2_sel = 2'd2; rot_next = 2'd2; end
    endcase
  end

  // rows above the first are the boundary row, value equals column index
  assign p1_val = (i_cnt == osa_pkg::LEN_W'(1)) ? j_cnt : row_rd[p1_sel];
  assign p2_val = (i_cnt == osa_pkg::LEN_W'(2)) ? j_cnt : row_rd[p2_sel];

  assign rd_addr = (cmd.row_init || status.j_last) ? '0 : j_cnt + osa_pkg::LEN_W'(1);
  assign a_addr  = i_cnt - osa_pkg::LEN_W'(1);

  assign del_c    = {1'b0, p1_val} + osa_pkg::SUM_W'(1);
  assign ins_c    = {1'b0, cur_left} + osa_pkg::SUM_W'(1);
  assign sub_c    = {1'b0, p1_left} + osa_pkg::SUM_W'(a_rd != b_rd);
  assign tr_c     = {1'b0, p2_d2} + osa_pkg::SUM_W'(1);
  assign trans_ok = (i_cnt > osa_pkg::LEN_W'(1)) && (j_cnt > osa_pkg::LEN_W'(1)) &&
                    (a_rd == b_prev) && (a_prev == b_rd);

  assign min1     = (del_c < ins_c) ? del_c : ins_c;
  assign min2     = (sub_c < min1) ? sub_c : min1;
  assign min3     = (trans_ok && (tr_c < min2)) ? tr_c : min2;
  assign cell_val = (j_cnt == '0) ? i_cnt : min3[osa_pkg::LEN_W-1:0];

  assign result      = status.m_zero ? len_b : (status.n_zero ? len_a : cur_left);
  assign result_wide = osa_pkg::SAT_W'(result);

  always_ff @(posedge clk) begin
    if (rst) begin
      len_a         <= '0;
      len_b         <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.load) begin
      unique case (osa_pkg::func_t'(func))
        osa_pkg::FUNC_CLEAR: begin
          len_a         <= '0;
          len_b         <= '0;
          overflow_seen <= 1'b0;
        end
        osa_pkg::FUNC_APPEND_A: begin
          if (a_room) len_a <= len_a + osa_pkg::LEN_W'(1);
          else        overflow_seen <= 1'b1;
        end
        osa_pkg::FUNC_APPEND_B: begin
          if (b_room) len_b <= len_b + osa_pkg::LEN_W'(1);
          else        overflow_seen <= 1'b1;
        end
        osa_pkg::FUNC_COMPUTE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && a_room && (osa_pkg::func_t'(func) == osa_pkg::FUNC_APPEND_A)) begin
      word_a[len_a[osa_pkg::IDX_W-1:0]] <= ch;
    end
    if (cmd.load && b_room && (osa_pkg::func_t'(func) == osa_pkg::FUNC_APPEND_B)) begin
      word_b[len_b[osa_pkg::IDX_W-1:0]] <= ch;
    end
    if (cmd.row_init) begin
      a_rd <= word_a[a_addr[osa_pkg::IDX_W-1:0]];
    end
    if (cmd.sweep && !status.j_last) begin
      b_rd <= word_b[j_cnt[osa_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < osa_pkg::NUM_ROWS; k++) begin
      if (cmd.sweep && (rot == osa_pkg::ROW_SEL_W'(k))) begin
        row_mem[k][j_cnt] <= cell_val;
      end
      if (cmd.row_init || cmd.sweep) begin
        row_rd[k] <= row_mem[k][rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_cnt <= osa_pkg::LEN_W'(1);
      rot   <= '0;
    end
    if (cmd.row_init) begin
      j_cnt  <= '0;
      a_prev <= a_rd;
    end
    if (cmd.sweep) begin
      j_cnt    <= j_cnt + osa_pkg::LEN_W'(1);
      b_prev   <= b_rd;
      p1_left  <= p1_val;
      p2_d1    <= p2_val;
      p2_d2    <= p2_d1;
      cur_left <= cell_val;
      if (status.j_last) begin
        i_cnt <= i_cnt + osa_pkg::LEN_W'(1);
        rot   <= rot_next;
      end
    end
    if (cmd.finish) begin
      truncated <= overflow_seen;
      if (result_wide > osa_pkg::SAT_W'(osa_pkg::DIST_MAX)) begin
        distance <= osa_pkg::DIST_W'(osa_pkg::DIST_MAX);
      end else begin
        distance <= result_wide[osa_pkg::DIST_W-1:0];
      end
    end
  end

endmodule

@@ rtl/osa_edit_distance.sv @@
// Clear and append words are accepted one word per cycle while idle.
// Compute: when either word is empty the result is the other word's length;
// otherwise the cell sweep handles one cell per cycle within a row on the
// three row memories. The next word is accepted once the result is in the
// output register. Reset empties both words and clears the truncation flag;
// stores need no clearing pass.
// ----------------------------------------------------------------------------
// OSA edit distance top level
// Optimal string alignment distance between two stored byte strings.
// ----------------------------------------------------------------------------
module osa_edit_distance (
  input  logic        clk,
  input  logic        rst,
  osa_req_if.sink     req,
  osa_rsp_if.source   rsp
);

  osa_pkg::ctrl_cmd_t    cmd;
  osa_pkg::ctrl_status_t status;

  osa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  osa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (req.func),
    .ch        (req.ch),
    .status    (status),
    .distance  (rsp.distance),
    .truncated (rsp.truncated)
  );

endmodule

@@ test/osa_edit_distance_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OSA edit distance testbench
// Drives clear, append and compute words into the request channel with random
// gaps, predicts each distance with an in-bench alignment sweep or takes it from
// the directed table, and checks every response word in order. Directed words
// come first, then random word pairs, mostly well-formed, with some noise.
// ----------------------------------------------------------------------------
module osa_edit_distance_tb;
  import osa_pkg::*;

  localparam int RAND_WORDS  = 1000;
  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE      = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              truncated;
  } osa_result_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  ch;
    int          reps;
    bit          typed;
    osa_result_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;

  plan_row_t plan [PLAN_ROWS] = '{
    '{FUNC_COMPUTE,  8'h00, 1,  1'b1, '{6'd0,  1'b0}},
    '{FUNC_APPEND_A, 8'h00, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_APPEND_A, 8'hFF, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'h00, 1,  1'b1, '{6'd2,  1'b0}},
    '{FUNC_APPEND_B, 8'hFF, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_APPEND_B, 8'h00, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'hFF, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_CLEAR,    8'hA5, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_APPEND_B, 8'h5A, 3,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'h5A, 1,  1'b1, '{6'd3,  1'b0}},
    '{FUNC_APPEND_A, 8'h5A, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_APPEND_A, 8'hC3, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'h00, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_CLEAR,    8'h00, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_APPEND_A, 8'hFF, 32, 1'b0, '{6'd0,  1'b0}},
    '{FUNC_APPEND_B, 8'h80, 32, 1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'h00, 1,  1'b1, '{6'd32, 1'b0}},
    '{FUNC_APPEND_A, 8'h01, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'h00, 1,  1'b1, '{6'd32, 1'b1}},
    '{FUNC_APPEND_B, 8'h7F, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_CLEAR,    8'hFF, 1,  1'b0, '{6'd0,  1'b0}},
    '{FUNC_COMPUTE,  8'h00, 1,  1'b1, '{6'd0,  1'b0}}
  };

  logic clk;
  logic rst;

  osa_req_if req ();
  osa_rsp_if rsp ();

  osa_edit_distance u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic [7:0]  word_a [MAX_LEN];
  logic [7:0]  word_b [MAX_LEN];
  int          len_a;
  int          len_b;
  bit          dropped;
  osa_result_t dist_q [$];
  osa_result_t want;
  int          err_cnt;
  int          idle_cycles;
  int          rand_words;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int edit_distance();
    int d [MAX_LEN+1][MAX_LEN+1];
    int i;
    int j;
    int best;
    for (i = 0; i <= len_a; i++) d[i][0] = i;
    for (j = 0; j <= len_b; j++) d[0][j] = j;
    for (i = 1; i <= len_a; i++) begin
      for (j = 1; j <= len_b; j++) begin
        best = d[i-1][j-1] + ((word_a[i-1] == word_b[j-1]) ? 0 : 1);
        if (d[i-1][j] + 1 < best) best = d[i-1][j] + 1;
        if (d[i][j-1] + 1 < best) best = d[i][j-1] + 1;
        if (i > 1 && j > 1 && word_a[i-1] == word_b[j-2] &&
            word_a[i-2] == word_b[j-1] && d[i-2][j-2] + 1 < best) begin
          best = d[i-2][j-2] + 1;
        end
        d[i][j] = best;
      end
    end
    return d[len_a][len_b];
  endfunction

  function automatic bit apply_word(func_t f, logic [7:0] c, output osa_result_t r);
    int span;
    r = '0;
    case (f)
      FUNC_CLEAR: begin
        len_a = 0;
        len_b = 0;
        dropped = 1'b0;
      end
      FUNC_APPEND_A: begin
        if (len_a < MAX_LEN) begin
          word_a[len_a] = c;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      FUNC_APPEND_B: begin
        if (len_b < MAX_LEN) begin
          word_b[len_b] = c;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      default: begin
        span = edit_distance();
        if (span > DIST_MAX) span = DIST_MAX;
        r.distance  = DIST_W'(span);
        r.truncated = dropped;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 19))
      0, 1:    return $urandom_range(MAX_LEN - 4, MAX_LEN);
      2:       return $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte(bit narrow, logic [7:0] base);
    if (narrow) return base + 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(func_t f, logic [7:0] c, bit typed, osa_result_t fixed);
    osa_result_t r;
    while (!calm && $urandom_range(0, 99) < 28) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= f;
    req.ch    <= c;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (apply_word(f, c, r)) dist_q.insert(dist_q.size(), typed ? fixed : r);
    @(negedge clk);
  endtask

  // drop valid and hold until every expected word has come back
  task automatic drain();
    req.valid <= 1'b0;
    do @(negedge clk); while (dist_q.size() != 0);
  endtask

  always @(negedge clk) begin
    rsp.ready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (dist_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("unexpected word: distance %0d truncated %0b", rsp.distance, rsp.truncated);
        end
      end else begin
        want = dist_q.pop_front();
        if (rsp.distance !== want.distance || rsp.truncated !== want.truncated) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch: expected distance %0d truncated %0b, %s %0d truncated %0b",
                     want.distance, want.truncated, "got distance",
                     rsp.distance, rsp.truncated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          r;
    int          k;
    int          la;
    int          lb;
    int          na;
    int          nb;
    bit          narrow;
    logic [7:0]  base;
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.func    = FUNC_CLEAR;
    req.ch      = 8'h00;
    rsp.ready   = 1'b0;
    len_a       = 0;
    len_b       = 0;
    dropped     = 1'b0;
    err_cnt     = 0;
    idle_cycles = 0;
    rand_words  = 0;
    calm        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (r = 0; r < PLAN_ROWS; r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        send_word(plan[r].func, plan[r].ch, plan[r].typed, plan[r].want);
      end
    end

    drain();
    while (rand_words < RAND_WORDS) begin
      calm = (rand_words >= 400 && rand_words < 650);
      if ($urandom_range(0, 14) == 0) drain();
      if ($urandom_range(0, 11) == 0) begin
        send_word(func_t'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
        rand_words++;
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          send_word(FUNC_CLEAR, 8'($urandom), 1'b0, '0);
          rand_words++;
        end
        la     = pick_len();
        lb     = pick_len();
        narrow = $urandom_range(0, 1);
        base   = 8'($urandom);
        na     = 0;
        nb     = 0;
        while (na < la || nb < lb) begin
          if (nb >= lb || (na < la && $urandom_range(0, 1) == 1)) begin
            send_word(FUNC_APPEND_A, pick_byte(narrow, base), 1'b0, '0);
            na++;
          end else begin
            send_word(FUNC_APPEND_B, pick_byte(narrow, base), 1'b0, '0);
            nb++;
          end
          rand_words++;
        end
        send_word(FUNC_COMPUTE, 8'($urandom), 1'b0, '0);
        rand_words++;
        if ($urandom_range(0, 7) == 0) begin
          send_word(FUNC_COMPUTE, 8'($urandom), 1'b0, '0);
          rand_words++;
        end
      end
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    while (dist_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0 && dist_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/osa_pkg.sv
rtl/osa_req_if.sv
rtl/osa_rsp_if.sv
rtl/osa_ctrl.sv
rtl/osa_datapath.sv
rtl/osa_edit_distance.sv
test/osa_edit_distance_tb.sv
